FILE: src/gras_pkg.sv
`timescale 1ns / 1ps

package gras_pkg;

    // item field widths
    localparam int FUNC_W = 3;
    localparam int POS_W  = 6;
    localparam int AMT_W  = 32;
    localparam int SUM_W  = 64;

    // configuration registers
    localparam int CFG_W  = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int RESET_ROWS_IN_USE = 64;
    localparam int RESET_COLS_IN_USE = 64;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE_BASE = 3'd0,
        FN_RECT_ADD   = 3'd1,
        FN_BUILD      = 3'd2,
        FN_QUERY      = 3'd3,
        FN_CLEAR      = 3'd4
    } t_func;

    typedef enum logic {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } t_reg_idx;

    // width of row/column index arithmetic: covers the padded grid,
    // the item position fields and the configuration registers, plus a carry bit
    function automatic int f_idx_w(input int max_rows, input int max_cols);
        int w;
        w = $clog2(max_rows + 2);
        if ($clog2(max_cols + 2) > w) w = $clog2(max_cols + 2);
        if (POS_W > w) w = POS_W;
        if (CFG_W > w) w = CFG_W;
        return w + 1;
    endfunction

endpackage

FILE: src/gras_cfg_regs.sv
`timescale 1ns / 1ps

module gras_cfg_regs #(
    parameter int MAX_ROWS = gras_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gras_pkg::DEF_MAX_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [gras_pkg::APB_AW-1:0]   i_paddr,
    input  logic [gras_pkg::APB_DW-1:0]   i_pwdata,
    output logic [gras_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready,
    output logic [gras_pkg::f_idx_w(MAX_ROWS, MAX_COLS)-1:0] o_eff_rows,
    output logic [gras_pkg::f_idx_w(MAX_ROWS, MAX_COLS)-1:0] o_eff_cols
);

    localparam int XW = gras_pkg::f_idx_w(MAX_ROWS, MAX_COLS);

    typedef logic [XW-1:0] t_idx;

    logic [gras_pkg::CFG_W-1:0] r_rows_in_use;
    logic [gras_pkg::CFG_W-1:0] r_cols_in_use;
    logic                       w_wr;
    gras_pkg::t_reg_idx         w_sel;

    // clamp to 1..max; zero behaves as one
    function automatic t_idx f_sat(input logic [gras_pkg::CFG_W-1:0] v, input t_idx lim);
        t_idx x;
        x = XW'(v);
        if (x == '0) return t_idx'(1);
        if (x > lim) return lim;
        return x;
    endfunction

    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign w_sel    = gras_pkg::t_reg_idx'(i_paddr[gras_pkg::APB_AW-1]);
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= gras_pkg::CFG_W'(gras_pkg::RESET_ROWS_IN_USE);
            r_cols_in_use <= gras_pkg::CFG_W'(gras_pkg::RESET_COLS_IN_USE);
        end else if (w_wr) begin
            unique case (w_sel)
                gras_pkg::REG_ROWS_IN_USE: r_rows_in_use <= i_pwdata[gras_pkg::CFG_W-1:0];
                gras_pkg::REG_COLS_IN_USE: r_cols_in_use <= i_pwdata[gras_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            gras_pkg::REG_ROWS_IN_USE: o_prdata = gras_pkg::APB_DW'(r_rows_in_use);
            gras_pkg::REG_COLS_IN_USE: o_prdata = gras_pkg::APB_DW'(r_cols_in_use);
            default:                   o_prdata = '0;
        endcase
    end

    assign o_eff_rows = f_sat(r_rows_in_use, t_idx'(MAX_ROWS));
    assign o_eff_cols = f_sat(r_cols_in_use, t_idx'(MAX_COLS));

endmodule

FILE: src/grid_rectangle_add_and_sum_core.sv
`timescale 1ns / 1ps

// Rectangle add / rectangle sum engine on a MAX_ROWS x MAX_COLS grid, built on a
// two-dimensional difference array held in one (MAX_ROWS+2) x (MAX_COLS+2) x 64-bit
// RAM, with the base cells in a second MAX_ROWS x MAX_COLS x 32-bit RAM. Items are
// taken one at a time. Rectangle add does one read-modify-write per corner through
// the single read and write port. A query also waits while the previous result still
// sits in the output register. Build makes four streaming passes over the rows and
// columns in use, one cell per cycle. Clear sweeps both RAMs, one RAM word per cycle.
// After reset the same clearing sweep runs with the input held stalled; register
// writes are taken throughout. All sums wrap at 64 bits.
module grid_rectangle_add_and_sum_core #(
    parameter int MAX_ROWS = gras_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gras_pkg::DEF_MAX_COLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [gras_pkg::FUNC_W-1:0]         i_func,
    input  logic [gras_pkg::POS_W-1:0]          i_top_row,
    input  logic [gras_pkg::POS_W-1:0]          i_left_col,
    input  logic [gras_pkg::POS_W-1:0]          i_bottom_row,
    input  logic [gras_pkg::POS_W-1:0]          i_right_col,
    input  logic signed [gras_pkg::AMT_W-1:0]   i_amount,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [gras_pkg::SUM_W-1:0]   o_rect_sum,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gras_pkg::APB_AW-1:0]         paddr,
    input  logic [gras_pkg::APB_DW-1:0]         pwdata,
    output logic [gras_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int XW      = gras_pkg::f_idx_w(MAX_ROWS, MAX_COLS);
    localparam int WSTRIDE = MAX_COLS + 2;
    localparam int WCELLS  = (MAX_ROWS + 2) * WSTRIDE;
    localparam int BCELLS  = MAX_ROWS * MAX_COLS;
    localparam int WAW     = $clog2(WCELLS);
    localparam int BAW     = (BCELLS > 1) ? $clog2(BCELLS) : 1;
    localparam int MW      = WAW + XW;
    localparam int NCORNER = 4;
    localparam int STEP_W  = $clog2(NCORNER + 1);
    localparam int SW      = gras_pkg::SUM_W;
    localparam int AW      = gras_pkg::AMT_W;

    localparam logic [1:0] PASS_ROW_A    = 2'd0;
    localparam logic [1:0] PASS_ROW_BASE = 2'd2;
    localparam logic [1:0] PASS_COL_B    = 2'd3;

    typedef logic [XW-1:0]  t_idx;
    typedef logic [WAW-1:0] t_waddr;
    typedef logic [BAW-1:0] t_baddr;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_QUERY,
        S_QOUT,
        S_BUILD,
        S_BDRAIN
    } t_state;

    function automatic t_waddr f_waddr(input t_idx r, input t_idx c);
        logic [MW-1:0] t;
        t = MW'(r) * MW'(WSTRIDE) + MW'(c);
        return t[WAW-1:0];
    endfunction

    function automatic t_baddr f_baddr(input t_idx r, input t_idx c);
        logic [MW-1:0] t;
        t = MW'(r) * MW'(MAX_COLS) + MW'(c);
        return t[BAW-1:0];
    endfunction

    // grids
    logic [SW-1:0] work_mem [WCELLS];
    logic [AW-1:0] base_mem [BCELLS];

    // memory ports
    logic          w_we;
    t_waddr        w_waddr;
    logic [SW-1:0] w_wdata;
    t_waddr        w_raddr;
    logic          b_we;
    t_baddr        b_waddr;
    logic [AW-1:0] b_wdata;
    t_baddr        b_raddr;
    logic [SW-1:0] r_wrd;
    logic [AW-1:0] r_brd;

    // control
    t_state              r_state;
    logic                r_built;
    t_waddr              r_clr;
    logic [STEP_W-1:0]   r_step;
    logic [1:0]          r_pass;
    t_idx                r_oi;
    t_idx                r_ii;
    logic                r_pw_valid;
    t_waddr              r_pw_addr;
    logic                r_pw_neg;
    logic                r_pw_first;
    logic                r_q_ok;
    logic                r_out_valid;

    // payload
    t_waddr              r_corner [NCORNER];
    logic [SW-1:0]       r_amt;
    logic [SW-1:0]       r_acc;
    logic signed [SW-1:0] r_out_data;

    // combinational
    t_idx          w_rows;
    t_idx          w_cols;
    logic          w_accept;
    t_idx          w_r1;
    t_idx          w_c1;
    t_idx          w_r2;
    t_idx          w_c2;
    logic          w_rect_ok;
    logic          w_cell_ok;
    logic          w_is_query;
    t_idx          w_ra;
    t_idx          w_rb;
    t_idx          w_ca;
    t_idx          w_cb;
    t_waddr        w_corner [NCORNER];
    logic [SW-1:0] w_amt64;
    logic          w_neg_step;
    logic          w_row_pass;
    t_idx          w_outer_max;
    t_idx          w_inner_max;
    t_idx          w_brow;
    t_idx          w_bcol;
    t_waddr        w_bld_addr;
    t_baddr        w_bld_baddr;
    logic [SW-1:0] w_build_sum;
    logic [SW-1:0] w_base_ext;

    gras_cfg_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .o_eff_rows (w_rows),
        .o_eff_cols (w_cols)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_rect_sum  = r_out_data;

    assign w_r1 = t_idx'(i_top_row);
    assign w_c1 = t_idx'(i_left_col);
    assign w_r2 = t_idx'(i_bottom_row);
    assign w_c2 = t_idx'(i_right_col);

    assign w_rect_ok  = (w_r1 <= w_r2) && (w_c1 <= w_c2) && (w_r2 < w_rows) && (w_c2 < w_cols);
    assign w_cell_ok  = (w_r1 < w_rows) && (w_c1 < w_cols);
    assign w_is_query = (gras_pkg::t_func'(i_func) == gras_pkg::FN_QUERY);
    assign w_amt64    = {{(SW-AW){i_amount[AW-1]}}, i_amount};

    // corner order (ra,ca)+ (ra,cb)- (rb,ca)- (rb,cb)+ serves both add and query
    always_comb begin
        if (w_is_query) begin
            w_ra = w_rect_ok ? w_r2 + t_idx'(1) : '0;
            w_rb = w_rect_ok ? w_r1 : '0;
            w_ca = w_rect_ok ? w_c2 + t_idx'(1) : '0;
            w_cb = w_rect_ok ? w_c1 : '0;
        end else begin
            w_ra = w_r1 + t_idx'(1);
            w_rb = w_r2 + t_idx'(2);
            w_ca = w_c1 + t_idx'(1);
            w_cb = w_c2 + t_idx'(2);
        end
    end

    assign w_corner[0] = f_waddr(w_ra, w_ca);
    assign w_corner[1] = f_waddr(w_ra, w_cb);
    assign w_corner[2] = f_waddr(w_rb, w_ca);
    assign w_corner[3] = f_waddr(w_rb, w_cb);

    // middle two corners carry the minus sign: steps 1 and 2
    assign w_neg_step = r_step[0] ^ r_step[1];

    // build pass walk: even passes run along rows, odd passes down columns
    assign w_row_pass  = !r_pass[0];
    assign w_outer_max = w_row_pass ? w_rows : w_cols;
    assign w_inner_max = w_row_pass ? w_cols : w_rows;
    assign w_brow      = w_row_pass ? r_oi : r_ii;
    assign w_bcol      = w_row_pass ? r_ii : r_oi;
    assign w_bld_addr  = f_waddr(w_brow, w_bcol);
    assign w_bld_baddr = f_baddr(w_brow - t_idx'(1), w_bcol - t_idx'(1));

    assign w_base_ext  = {{(SW-AW){r_brd[AW-1]}}, r_brd};
    assign w_build_sum = r_wrd + (r_pw_first ? '0 : r_acc)
                       + ((r_pass == PASS_ROW_BASE) ? w_base_ext : '0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pw_addr;
        w_wdata = w_build_sum;
        w_raddr = '0;
        b_we    = 1'b0;
        b_waddr = f_baddr(w_r1, w_c1);
        b_wdata = i_amount;
        b_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                b_we    = ({1'b0, r_clr} < (WAW+1)'(BCELLS));
                b_waddr = r_clr[BAW-1:0];
                b_wdata = '0;
            end
            S_IDLE: begin
                b_we = w_accept && !r_built && w_cell_ok
                    && (gras_pkg::t_func'(i_func) == gras_pkg::FN_WRITE_BASE);
            end
            S_ADD: begin
                w_raddr = r_corner[0];
                w_we    = r_pw_valid;
                w_wdata = r_pw_neg ? r_wrd - r_amt : r_wrd + r_amt;
            end
            S_QUERY: begin
                w_raddr = r_corner[0];
            end
            S_BUILD: begin
                w_raddr = w_bld_addr;
                b_raddr = w_bld_baddr;
                w_we    = r_pw_valid;
            end
            S_BDRAIN: begin
                w_we = r_pw_valid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) work_mem[w_waddr] <= w_wdata;
        r_wrd <= work_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) base_mem[b_waddr] <= b_wdata;
        r_brd <= base_mem[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_built     <= 1'b0;
            r_step      <= '0;
            r_pass      <= PASS_ROW_A;
            r_pw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_QOUT drives the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_QOUT)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == t_waddr'(WCELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_amt  <= w_amt64;
                        r_acc  <= '0;
                        r_step <= '0;
                        r_q_ok <= w_rect_ok && r_built;
                        for (int k = 0; k < NCORNER; k++) r_corner[k] <= w_corner[k];
                        unique case (gras_pkg::t_func'(i_func))
                            gras_pkg::FN_WRITE_BASE: ;  // done on the base RAM port
                            gras_pkg::FN_RECT_ADD: begin
                                if (!r_built && w_rect_ok) r_state <= S_ADD;
                            end
                            gras_pkg::FN_BUILD: begin
                                if (!r_built) begin
                                    r_state <= S_BUILD;
                                    r_pass  <= PASS_ROW_A;
                                    r_oi    <= t_idx'(1);
                                    r_ii    <= t_idx'(1);
                                end
                            end
                            gras_pkg::FN_QUERY: r_state <= S_QUERY;
                            gras_pkg::FN_CLEAR: begin
                                r_state <= S_CLEAR;
                                r_clr   <= '0;
                                r_built <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD: begin
                    if (r_step == STEP_W'(NCORNER)) begin
                        r_state    <= S_IDLE;
                        r_pw_valid <= 1'b0;
                    end else begin
                        r_pw_valid <= 1'b1;
                        r_pw_addr  <= r_corner[0];
                        r_pw_neg   <= w_neg_step;
                        for (int k = 0; k < NCORNER - 1; k++) r_corner[k] <= r_corner[k+1];
                        r_corner[NCORNER-1] <= r_corner[0];
                    end
                    r_step <= r_step + 1'b1;
                end
                S_QUERY: begin
                    if (r_step != '0) begin
                        r_acc <= r_pw_neg ? r_acc - r_wrd : r_acc + r_wrd;
                    end
                    if (r_step == STEP_W'(NCORNER)) begin
                        r_state <= S_QOUT;
                    end else begin
                        r_pw_neg <= w_neg_step;
                        for (int k = 0; k < NCORNER - 1; k++) r_corner[k] <= r_corner[k+1];
                        r_corner[NCORNER-1] <= r_corner[0];
                    end
                    r_step <= r_step + 1'b1;
                end
                S_QOUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_q_ok ? r_acc : '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_BUILD: begin
                    if (r_pw_valid) r_acc <= w_build_sum;
                    r_pw_valid <= 1'b1;
                    r_pw_addr  <= w_bld_addr;
                    r_pw_first <= (r_ii == t_idx'(1));
                    if (r_ii == w_inner_max) begin
                        r_ii <= t_idx'(1);
                        if (r_oi == w_outer_max) begin
                            r_oi    <= t_idx'(1);
                            r_state <= S_BDRAIN;
                        end else begin
                            r_oi <= r_oi + t_idx'(1);
                        end
                    end else begin
                        r_ii <= r_ii + t_idx'(1);
                    end
                end
                S_BDRAIN: begin
                    // last write of the pass lands here; next pass reads after it
                    r_pw_valid <= 1'b0;
                    if (r_pass == PASS_COL_B) begin
                        r_built <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pass  <= r_pass + 1'b1;
                        r_state <= S_BUILD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/grid_rectangle_add_and_sum_core_test.sv
`timescale 1ns / 1ps

module grid_rectangle_add_and_sum_core_test;
    import gras_pkg::*;

    localparam int GRID_ROWS   = DEF_MAX_ROWS;
    localparam int GRID_COLS   = DEF_MAX_COLS;
    localparam int WORK_STRIDE = GRID_COLS + 2;
    localparam int WORK_CELLS  = (GRID_ROWS + 2) * WORK_STRIDE;
    localparam int BASE_CELLS  = GRID_ROWS * GRID_COLS;
    localparam int FUNC_MAX    = (1 << FUNC_W) - 1;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int CFG_MAX     = (1 << CFG_W) - 1;
    localparam int SMALL_DIM   = 8;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [FUNC_W-1:0]        i_func;
    logic [POS_W-1:0]         i_top_row;
    logic [POS_W-1:0]         i_left_col;
    logic [POS_W-1:0]         i_bottom_row;
    logic [POS_W-1:0]         i_right_col;
    logic signed [AMT_W-1:0]  i_amount;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [SUM_W-1:0]  o_rect_sum;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    // shadow of the grid engine
    logic [SUM_W-1:0]  work_cells [WORK_CELLS];
    logic [AMT_W-1:0]  base_cells [BASE_CELLS];
    bit                grid_built;
    logic [CFG_W-1:0]  rows_cfg;
    logic [CFG_W-1:0]  cols_cfg;
    logic [SUM_W-1:0]  expected_sums [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_idle_pct;

    grid_rectangle_add_and_sum_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_top_row    (i_top_row),
        .i_left_col   (i_left_col),
        .i_bottom_row (i_bottom_row),
        .i_right_col  (i_right_col),
        .i_amount     (i_amount),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_rect_sum   (o_rect_sum),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_rectangle_add_and_sum_core_test: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- shadow grid

    function automatic int clamp_dim(input logic [CFG_W-1:0] value, input int limit);
        int d;
        d = int'(value);
        if (d == 0) d = 1;
        if (d > limit) d = limit;
        return d;
    endfunction

    function automatic int widx(input int row, input int col);
        return row * WORK_STRIDE + col;
    endfunction

    function automatic void run_prefix_passes(input int n, input int m);
        for (int i = 1; i <= n; i++)
            for (int j = 1; j <= m; j++)
                work_cells[widx(i, j)] += work_cells[widx(i, j - 1)];
        for (int j = 1; j <= m; j++)
            for (int i = 2; i <= n; i++)
                work_cells[widx(i, j)] += work_cells[widx(i - 1, j)];
    endfunction

    function automatic void clear_grids();
        for (int i = 0; i < WORK_CELLS; i++) work_cells[i] = '0;
        for (int i = 0; i < BASE_CELLS; i++) base_cells[i] = '0;
        grid_built = 1'b0;
    endfunction

    function automatic void build_prefix_sums();
        int n;
        int m;
        logic [AMT_W-1:0] b;
        n = clamp_dim(rows_cfg, GRID_ROWS);
        m = clamp_dim(cols_cfg, GRID_COLS);
        // difference marks -> per-cell increments, plus base, -> 2D prefix sums
        run_prefix_passes(n, m);
        for (int i = 1; i <= n; i++)
            for (int j = 1; j <= m; j++) begin
                b = base_cells[(i - 1) * GRID_COLS + (j - 1)];
                work_cells[widx(i, j)] += {{(SUM_W - AMT_W){b[AMT_W-1]}}, b};
            end
        run_prefix_passes(n, m);
        grid_built = 1'b1;
    endfunction

    function automatic void apply_grid_item(input logic [FUNC_W-1:0] fn,
                                            input int r1, input int c1,
                                            input int r2, input int c2,
                                            input logic [AMT_W-1:0] amt);
        int n;
        int m;
        bit rect_ok;
        logic [SUM_W-1:0] k;
        logic [SUM_W-1:0] s;
        n = clamp_dim(rows_cfg, GRID_ROWS);
        m = clamp_dim(cols_cfg, GRID_COLS);
        rect_ok = r1 <= r2 && c1 <= c2 && r2 < n && c2 < m;
        k = {{(SUM_W - AMT_W){amt[AMT_W-1]}}, amt};
        case (fn)
            FN_WRITE_BASE: begin
                if (!grid_built && r1 < n && c1 < m) base_cells[r1 * GRID_COLS + c1] = amt;
            end
            FN_RECT_ADD: begin
                if (!grid_built && rect_ok) begin
                    work_cells[widx(r1 + 1, c1 + 1)] += k;
                    work_cells[widx(r1 + 1, c2 + 2)] -= k;
                    work_cells[widx(r2 + 2, c1 + 1)] -= k;
                    work_cells[widx(r2 + 2, c2 + 2)] += k;
                end
            end
            FN_BUILD: begin
                if (!grid_built) build_prefix_sums();
            end
            FN_QUERY: begin
                s = '0;
                if (grid_built && rect_ok)
                    s = work_cells[widx(r2 + 1, c2 + 1)] - work_cells[widx(r1, c2 + 1)]
                        - work_cells[widx(r2 + 1, c1)] + work_cells[widx(r1, c1)];
                expected_sums.push_back(s);
            end
            FN_CLEAR: begin
                clear_grids();
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        logic [SUM_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("rect_sum %h with no query pending", o_rect_sum));
            end else begin
                want = expected_sums.pop_front();
                if (o_rect_sum !== want)
                    report_mismatch($sformatf("rect_sum got %h want %h", o_rect_sum, want));
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = int'($urandom_range(99)) < recv_idle_pct;
        end
    end

    // ---------------------------------------------------------------- driving

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_item(input logic [FUNC_W-1:0] fn, input int r1, input int c1,
                             input int r2, input int c2, input logic [AMT_W-1:0] amt);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_func       = fn;
        i_top_row    = POS_W'(r1);
        i_left_col   = POS_W'(c1);
        i_bottom_row = POS_W'(r2);
        i_right_col  = POS_W'(c2);
        i_amount     = amt;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        apply_grid_item(fn, r1, c1, r2, c2, amt);
        @(negedge i_clk);
    endtask

    function automatic int pick_pos(input int lim);
        if ($urandom_range(19) == 0) return int'($urandom_range(POS_MAX));
        return int'($urandom_range(lim - 1));
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        if ($urandom_range(3) == 0) return AMT_W'(int'($urandom_range(32)) - 16);
        return AMT_W'($urandom());
    endfunction

    task automatic send_rect(input logic [FUNC_W-1:0] fn, input int n, input int m);
        int ra;
        int rb;
        int ca;
        int cb;
        ra = pick_pos(n);
        rb = pick_pos(n);
        ca = pick_pos(m);
        cb = pick_pos(m);
        // mostly ordered corners; the rest keep whatever order they came in
        if ($urandom_range(9) != 0) begin
            if (ra > rb) {ra, rb} = {rb, ra};
            if (ca > cb) {ca, cb} = {cb, ca};
        end
        send_item(fn, ra, ca, rb, cb, pick_amount());
    endtask

    task automatic send_noise_item();
        send_item(FUNC_W'($urandom_range(FUNC_MAX)), pick_pos(POS_MAX + 1),
                  pick_pos(POS_MAX + 1), pick_pos(POS_MAX + 1), pick_pos(POS_MAX + 1),
                  AMT_W'($urandom()));
    endtask

    // drain results, then cover a build or clear sweep that may still be running
    task automatic wait_idle();
        int settle;
        i_in_valid = 1'b0;
        while (expected_sums.size() != 0) @(negedge i_clk);
        settle = 4 * (clamp_dim(rows_cfg, GRID_ROWS) * clamp_dim(cols_cfg, GRID_COLS) + 1)
                 + WORK_CELLS + 64;
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(4 * int'(idx));
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ROWS_IN_USE) rows_cfg = value[CFG_W-1:0];
        else cols_cfg = value[CFG_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_grid_size(input logic [APB_DW-1:0] rows_val,
                                 input logic [APB_DW-1:0] cols_val);
        wait_idle();
        write_reg(REG_ROWS_IN_USE, rows_val);
        write_reg(REG_COLS_IN_USE, cols_val);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_full_grid_directed();
        send_item(FN_QUERY, 0, 0, POS_MAX, POS_MAX, '0);                 // not built yet
        send_item(FN_WRITE_BASE, 0, 0, 0, 0, 32'h8000_0000);
        send_item(FN_WRITE_BASE, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 32'h7FFF_FFFF);
        send_item(FN_RECT_ADD, 0, 0, POS_MAX, POS_MAX, 32'h7FFF_FFFF);
        send_item(FN_RECT_ADD, 5, 0, 4, POS_MAX, 32'd123);                // rows reversed
        send_item(FN_RECT_ADD, 0, 9, POS_MAX, 8, 32'd77);                 // cols reversed
        send_item(FN_BUILD, 0, 0, 0, 0, '0);
        send_item(FN_BUILD, 0, 0, 0, 0, '0);
        send_item(FN_WRITE_BASE, 1, 1, 0, 0, 32'd555);
        send_item(FN_RECT_ADD, 0, 0, 0, 0, 32'd9);
        send_item(FN_QUERY, 0, 0, POS_MAX, POS_MAX, '1);
        send_item(FN_QUERY, POS_MAX, POS_MAX, POS_MAX, POS_MAX, '0);
        send_item(FN_QUERY, 10, 0, 9, 0, '0);
        for (int f = int'(FN_CLEAR) + 1; f <= FUNC_MAX; f++)
            send_item(FUNC_W'(f), POS_MAX, POS_MAX, POS_MAX, POS_MAX, '1);
        send_item(FN_CLEAR, 0, 0, 0, 0, '0);
        send_item(FN_QUERY, 0, 0, POS_MAX, POS_MAX, '0);
    endtask

    task automatic test_size_limits();
        // zero rows acts as one; upper pwdata bits are not part of the register
        set_grid_size(32'hFFFF_FF80, CFG_MAX);
        send_item(FN_CLEAR, 0, 0, 0, 0, '0);
        send_item(FN_WRITE_BASE, 1, 0, 0, 0, 32'd42);
        send_item(FN_RECT_ADD, 0, 0, 0, POS_MAX, 32'hFFFF_FFFD);
        send_item(FN_RECT_ADD, 0, 0, 1, 0, 32'd1000);
        send_item(FN_BUILD, 0, 0, 0, 0, '0);
        send_item(FN_QUERY, 0, 0, 0, POS_MAX, '0);
        send_item(FN_QUERY, 0, 0, 1, 1, '0);
    endtask

    task automatic test_resize_before_build();
        set_grid_size(SMALL_DIM, SMALL_DIM);
        send_item(FN_CLEAR, 0, 0, 0, 0, '0);
        send_item(FN_RECT_ADD, 2, 2, 7, 7, 32'd11);
        send_item(FN_WRITE_BASE, 5, 5, 0, 0, 32'hFFFF_FF00);
        set_grid_size(4, 6);
        send_item(FN_BUILD, 0, 0, 0, 0, '0);
        send_item(FN_QUERY, 0, 0, 3, 5, '0);
        // grow again: the cells outside the built area still hold raw marks
        set_grid_size(SMALL_DIM, SMALL_DIM);
        send_item(FN_QUERY, 0, 0, 7, 7, '0);
    endtask

    task automatic random_grid_phase(input bit full_size);
        int n;
        int m;
        logic [APB_DW-1:0] rows_val;
        logic [APB_DW-1:0] cols_val;
        rows_val = $urandom();
        cols_val = $urandom();
        if (full_size) begin
            rows_val[CFG_W-1:0] = CFG_W'($urandom_range(CFG_MAX, GRID_ROWS));
            cols_val[CFG_W-1:0] = CFG_W'($urandom_range(CFG_MAX, GRID_COLS));
        end else begin
            rows_val[CFG_W-1:0] = CFG_W'($urandom_range(SMALL_DIM));
            cols_val[CFG_W-1:0] = CFG_W'($urandom_range(SMALL_DIM));
        end
        set_grid_size(rows_val, cols_val);
        n = clamp_dim(rows_cfg, GRID_ROWS);
        m = clamp_dim(cols_cfg, GRID_COLS);

        if ($urandom_range(9) != 0) send_item(FN_CLEAR, 0, 0, 0, 0, pick_amount());
        repeat ($urandom_range(16, 4)) begin
            case ($urandom_range(9))
                0, 1, 2: send_item(FN_WRITE_BASE, pick_pos(n), pick_pos(m),
                                   int'($urandom_range(POS_MAX)),
                                   int'($urandom_range(POS_MAX)), pick_amount());
                9: send_noise_item();
                default: send_rect(FN_RECT_ADD, n, m);
            endcase
        end
        if ($urandom_range(9) != 0) send_item(FN_BUILD, 0, 0, 0, 0, pick_amount());
        repeat ($urandom_range(20, 8)) begin
            case ($urandom_range(19))
                0: send_noise_item();
                1: send_rect(FN_RECT_ADD, n, m);
                default: send_rect(FN_QUERY, n, m);
            endcase
        end
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int p = 0; p < 8; p++) random_grid_phase(p == 0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = '0;
        i_top_row    = '0;
        i_left_col   = '0;
        i_bottom_row = '0;
        i_right_col  = '0;
        i_amount     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rows_cfg      = CFG_W'(RESET_ROWS_IN_USE);
        cols_cfg      = CFG_W'(RESET_COLS_IN_USE);
        send_idle_pct = 13;
        recv_idle_pct = 52;
        clear_grids();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_full_grid_directed();
        test_size_limits();
        test_resize_before_build();
        test_random_traffic(13, 52);
        test_random_traffic(52, 13);
        test_random_traffic(0, 0);

        wait_idle();
        if (error_count == 0) begin
            $display("grid_rectangle_add_and_sum_core_test: PASS");
        end else begin
            $display("grid_rectangle_add_and_sum_core_test: FAIL");
        end
        $finish;
    end

endmodule
